### src/bprs_pkg.sv
package bprs_pkg;

  localparam int PIXELS_PER_GROUP = 16;
  localparam int CNT_W            = $clog2(PIXELS_PER_GROUP);
  localparam int PLANE_W          = 16;
  localparam int PAL_DEPTH        = 16;
  localparam int PAL_IDX_W        = 4;
  localparam int PAL_VAL_W        = 12;
  localparam int NUM_CHAN         = 3;
  localparam int SUM_W            = 10;
  localparam int PROD_W           = 20;

  // divide by three: x * 683 >> 11, exact for x < 2048
  localparam logic [PROD_W-1:0] DIV3_MUL   = 20'd683;
  localparam int                DIV3_SHIFT = 11;

  localparam logic [7:0] ALPHA_FULL = 8'hFF;

  localparam logic [1:0] MODE_LOW  = 2'd0;
  localparam logic [1:0] MODE_MED  = 2'd1;
  localparam logic [1:0] MODE_MONO = 2'd2;

  localparam logic REQ_PALETTE = 1'b0;
  localparam logic REQ_GROUP   = 1'b1;

  typedef struct packed {
    logic [2:0] n0;
    logic [2:0] n1;
    logic [1:0] level;
  } chan_req_t;

  typedef struct packed {
    chan_req_t [NUM_CHAN-1:0] ch;
    logic                     last;
  } pix_req_t;

  function automatic logic [7:0] nib_level(input logic [2:0] n);
    logic [7:0] v;
    unique case (n)
      3'd0:    v = 8'd0;
      3'd1:    v = 8'd36;
      3'd2:    v = 8'd73;
      3'd3:    v = 8'd109;
      3'd4:    v = 8'd146;
      3'd5:    v = 8'd182;
      3'd6:    v = 8'd219;
      default: v = 8'd255;
    endcase
    return v;
  endfunction

endpackage

### src/bprs_in_if.sv
interface bprs_in_if;
  logic        valid;
  logic        ready;
  logic        req_type;
  logic [3:0]  palette_index;
  logic [11:0] palette_value;
  logic [15:0] plane_zero;
  logic [15:0] plane_one;
  logic [15:0] plane_two;
  logic [15:0] plane_three;

  modport source (
    output valid, req_type, palette_index, palette_value,
           plane_zero, plane_one, plane_two, plane_three,
    input  ready
  );

  modport sink (
    input  valid, req_type, palette_index, palette_value,
           plane_zero, plane_one, plane_two, plane_three,
    output ready
  );
endinterface

### src/bprs_out_if.sv
interface bprs_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] pixel_rgba;
  logic        last_pixel;

  modport source (
    output valid, pixel_rgba, last_pixel,
    input  ready
  );

  modport sink (
    input  valid, pixel_rgba, last_pixel,
    output ready
  );
endinterface

### src/bprs_ser.sv
module bprs_ser (
  input  logic                clk,
  input  logic                rst_n,
  bprs_in_if.sink             in_if,
  input  logic [1:0]          mode,
  input  logic                adv,
  output bprs_pkg::pix_req_t  req_o,
  output logic                req_valid_o
);

  localparam logic [bprs_pkg::CNT_W-1:0] LAST_CNT =
    bprs_pkg::CNT_W'(bprs_pkg::PIXELS_PER_GROUP - 1);

  logic                                grp_valid_r, grp_valid_nxt;
  logic [bprs_pkg::CNT_W-1:0]          cnt_r, cnt_nxt;
  logic [bprs_pkg::PLANE_W-1:0]        p0_r, p1_r, p2_r, p3_r;
  logic [bprs_pkg::PAL_VAL_W-1:0]      pal_r [bprs_pkg::PAL_DEPTH];
  bprs_pkg::pix_req_t                  req_r, req_nxt;
  logic                                req_valid_r;

  logic                                acc, step, last_step;
  logic [bprs_pkg::PAL_IDX_W-1:0]      idx;
  logic [bprs_pkg::PAL_VAL_W-1:0]      entry;
  logic                                mono;

  assign step      = grp_valid_r && adv;
  assign last_step = step && (cnt_r == LAST_CNT);
  assign in_if.ready = !grp_valid_r || last_step;
  assign acc       = in_if.valid && in_if.ready;

  always_comb begin
    grp_valid_nxt = grp_valid_r;
    cnt_nxt       = cnt_r;
    if (last_step) begin
      grp_valid_nxt = 1'b0;
    end else if (step) begin
      cnt_nxt = cnt_r + 1'b1;
    end
    if (acc && in_if.req_type == bprs_pkg::REQ_GROUP) begin
      grp_valid_nxt = 1'b1;
      cnt_nxt       = '0;
    end
  end

  // planes shift out MSB first
  always_ff @(posedge clk) begin
    if (acc && in_if.req_type == bprs_pkg::REQ_GROUP) begin
      p0_r <= in_if.plane_zero;
      p1_r <= in_if.plane_one;
      p2_r <= in_if.plane_two;
      p3_r <= in_if.plane_three;
    end else if (step) begin
      p0_r <= p0_r << 1;
      p1_r <= p1_r << 1;
      p2_r <= p2_r << 1;
      p3_r <= p3_r << 1;
    end
  end

  always_comb begin
    mono = (mode == bprs_pkg::MODE_MONO);
    unique case (mode)
      bprs_pkg::MODE_MED,
      bprs_pkg::MODE_MONO: idx = {2'b00, p1_r[15], p0_r[15]};
      default:             idx = {p3_r[15], p2_r[15], p1_r[15], p0_r[15]};
    endcase
    entry = pal_r[idx];
    for (int s = 0; s < bprs_pkg::NUM_CHAN; s++) begin
      if (mono) begin
        req_nxt.ch[s].n0    = pal_r[0][4*s +: 3];
        req_nxt.ch[s].n1    = pal_r[1][4*s +: 3];
        req_nxt.ch[s].level = idx[1:0];
      end else begin
        req_nxt.ch[s].n0    = entry[4*s +: 3];
        req_nxt.ch[s].n1    = 3'd0;
        req_nxt.ch[s].level = 2'd0;
      end
    end
    req_nxt.last = (cnt_r == LAST_CNT);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      grp_valid_r <= 1'b0;
      cnt_r       <= '0;
      req_valid_r <= 1'b0;
      for (int i = 0; i < bprs_pkg::PAL_DEPTH; i++) begin
        pal_r[i] <= '0;
      end
    end else begin
      grp_valid_r <= grp_valid_nxt;
      cnt_r       <= cnt_nxt;
      if (adv) begin
        req_valid_r <= grp_valid_r;
      end
      if (acc && in_if.req_type == bprs_pkg::REQ_PALETTE) begin
        pal_r[in_if.palette_index] <= in_if.palette_value;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      req_r <= req_nxt;
    end
  end

  assign req_o       = req_r;
  assign req_valid_o = req_valid_r;

endmodule

### src/bprs_lane.sv
module bprs_lane (
  input  logic                clk,
  input  logic                adv,
  input  bprs_pkg::chan_req_t req,
  output logic [7:0]          val
);

  logic [bprs_pkg::SUM_W-1:0]  sum_r, sum_nxt;
  logic [bprs_pkg::PROD_W-1:0] prod;

  // weighted sum of the two levels; plain pixels come in with level zero
  always_comb begin
    sum_nxt = bprs_pkg::SUM_W'(bprs_pkg::nib_level(req.n0))
                * bprs_pkg::SUM_W'(2'd3 - req.level)
            + bprs_pkg::SUM_W'(bprs_pkg::nib_level(req.n1))
                * bprs_pkg::SUM_W'(req.level);
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      sum_r <= sum_nxt;
    end
  end

  assign prod = bprs_pkg::PROD_W'(sum_r) * bprs_pkg::DIV3_MUL;
  assign val  = prod[bprs_pkg::DIV3_SHIFT +: 8];

endmodule

### src/bitplane_to_rgba_shifter.sv
// Bitplane to RGBA shifter.
// in_if carries two kinds of transaction: a palette write (req_type 0) that
// stores a 12-bit colour in one of 16 entries and yields nothing, and a pixel
// group (req_type 1) of four 16-bit plane words that yields 16 pixels on
// out_if, MSB first, with last_pixel set on the sixteenth.
// cfg_we/cfg_wdata set the resolution mode (low, medium, mono blend); write it
// only while the block is idle.
// Each pixel passes the serialiser request register, the lane sum register
// and the output register. Throughput: one pixel per cycle, set by the
// single-pixel serialiser, while out_if.ready does not stall. A palette
// write or the next group is taken in the cycle the previous group's last
// pixel leaves the serialiser, so back-to-back groups stream without gaps.
// Reset clears the palette to zero, sets low resolution and empties the
// pipeline. When the receiver holds out_if.ready low, the whole pipeline
// freezes; the serialiser can still load one group while frozen.
module bitplane_to_rgba_shifter (
  input  logic        clk,
  input  logic        rst_n,
  bprs_in_if.sink     in_if,
  bprs_out_if.source  out_if,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_wdata
);

  logic [1:0]           mode_r;
  logic                 adv;
  bprs_pkg::pix_req_t   req;
  logic                 req_valid;

  // lane stage control
  logic                 c_valid_r;
  logic                 c_last_r;

  // output register
  logic                 out_valid_r;
  logic [31:0]          pixel_r, pixel_nxt;
  logic                 last_r;

  logic [7:0]           lane_val [bprs_pkg::NUM_CHAN];

  // stall-all pipeline, moves whenever the output register can take data
  assign adv = !out_valid_r || out_if.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= bprs_pkg::MODE_LOW;
    end else if (cfg_we) begin
      mode_r <= cfg_wdata;
    end
  end

  // serialiser and palette lookup
  bprs_ser u_ser (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_if       (in_if),
    .mode        (mode_r),
    .adv         (adv),
    .req_o       (req),
    .req_valid_o (req_valid)
  );

  // one lane per colour channel: blue, green, red
  for (genvar s = 0; s < bprs_pkg::NUM_CHAN; s++) begin : g_lane
    bprs_lane u_lane (
      .clk (clk),
      .adv (adv),
      .req (req.ch[s]),
      .val (lane_val[s])
    );
  end

  // merge lanes into one RGBA word
  assign pixel_nxt = {lane_val[2], lane_val[1], lane_val[0], bprs_pkg::ALPHA_FULL};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c_valid_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (adv) begin
      c_valid_r   <= req_valid;
      out_valid_r <= c_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      c_last_r <= req.last;
      pixel_r  <= pixel_nxt;
      last_r   <= c_last_r;
    end
  end

  assign out_if.valid      = out_valid_r;
  assign out_if.pixel_rgba = pixel_r;
  assign out_if.last_pixel = last_r;

endmodule
